/* rtl/core/lru_block_cache_tags_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros used by the back end of the block cache tag logic
// ----------------------------------------------------------------------------
`ifndef LRU_BLOCK_CACHE_TAGS_ASSERT_SVH
`define LRU_BLOCK_CACHE_TAGS_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define LBCT_ASSERT_NOW(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset
`define LBCT_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/lbct_pkg.sv */
// ----------------------------------------------------------------------------
// lbct_pkg
// Shared types, sizes and helpers of the block cache tag logic.
// ----------------------------------------------------------------------------
package lbct_pkg;

  // Cache geometry
  localparam int WAYS   = 16;
  localparam int IDX_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int TAG_W  = 31;
  localparam int AGE_W  = 32;
  localparam int WORD_W = 32;
  localparam int WAY_W  = 4;

  // Command queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  // Stream payload widths
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 40;

  localparam logic [IDX_W-1:0] LAST_WAY = IDX_W'(WAYS - 1);
  localparam logic [TAG_W-1:0] TAG_MAX  = {TAG_W{1'b1}};

  // Classified request handed from front to back
  typedef struct packed {
    logic             bypass;
    logic [TAG_W-1:0] tag;
  } item_t;

  // Back-end sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  // Low bits of a way index as reported on the result
  function automatic logic [WAY_W-1:0] way_field(input logic [IDX_W-1:0] idx);
    logic [IDX_W+WAY_W-1:0] wide;
    wide = (IDX_W+WAY_W)'(idx);
    return wide[WAY_W-1:0];
  endfunction

endpackage

/* rtl/core/lbct_front.sv */
// ----------------------------------------------------------------------------
// lbct_front
// Accepts block words, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
module lbct_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [lbct_pkg::IN_DATA_W-1:0] s_axis_tdata,  // [31:0] block_offset
  output logic                         q_valid,
  input  logic                         q_pop,
  output lbct_pkg::item_t              q_item
);

  lbct_pkg::item_t                  q_mem [lbct_pkg::QDEPTH];
  logic [lbct_pkg::QPTR_W-1:0]      wr_ptr;
  logic [lbct_pkg::QPTR_W-1:0]      rd_ptr;
  logic [lbct_pkg::QCNT_W-1:0]      count;
  logic [lbct_pkg::WORD_W-1:0]      neg_word;
  lbct_pkg::item_t                  cls;
  logic                             push;
  logic                             pop;

  // Classify: non-negative word bypasses, negative word gives saturated magnitude
  always_comb begin
    neg_word   = (~s_axis_tdata) + lbct_pkg::WORD_W'(1);
    cls.bypass = ~s_axis_tdata[lbct_pkg::WORD_W-1];
    if (cls.bypass) begin
      cls.tag = s_axis_tdata[lbct_pkg::TAG_W-1:0];
    end else if (neg_word[lbct_pkg::WORD_W-1]) begin
      cls.tag = lbct_pkg::TAG_MAX;
    end else begin
      cls.tag = neg_word[lbct_pkg::TAG_W-1:0];
    end
  end

  // Queue handshake
  assign s_axis_tready = (count != lbct_pkg::QCNT_W'(lbct_pkg::QDEPTH));
  assign q_valid       = (count != '0);
  assign push          = s_axis_tvalid && s_axis_tready;
  assign pop           = q_pop && q_valid;
  assign q_item        = q_mem[rd_ptr];

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= cls;
    end
  end

  // Queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + lbct_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + lbct_pkg::QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + lbct_pkg::QCNT_W'(1);
        2'b01:   count <= count - lbct_pkg::QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

/* rtl/core/lbct_back.sv */
// ----------------------------------------------------------------------------
// lbct_back
// Scans the ways one per cycle for a tag match and the oldest entry,
// updates tags and age stamps, and drives the result register.
// ----------------------------------------------------------------------------
`include "lru_block_cache_tags_assert.svh"

module lbct_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_valid,
  output logic                          q_pop,
  input  lbct_pkg::item_t               q_item,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [lbct_pkg::OUT_DATA_W-1:0] m_axis_tdata,  // [0] hit, [4:1] way,
                                                          // [35:5] block_number, rest 0
  output logic                          m_axis_tuser   // [0] bypass
);

  lbct_pkg::state_t                 state;
  lbct_pkg::state_t                 state_next;
  lbct_pkg::item_t                  work;
  logic [lbct_pkg::TAG_W-1:0]       way_tags [lbct_pkg::WAYS];
  logic [lbct_pkg::AGE_W-1:0]       way_ages [lbct_pkg::WAYS];
  logic [lbct_pkg::AGE_W-1:0]       age_counter;
  logic [lbct_pkg::AGE_W-1:0]       age_next;
  logic [lbct_pkg::IDX_W-1:0]       idx;
  logic [lbct_pkg::AGE_W-1:0]       best_age;
  logic [lbct_pkg::IDX_W-1:0]       best_idx;
  logic                             sel_hit;
  logic [lbct_pkg::IDX_W-1:0]       sel_idx;
  logic                             tag_match;
  logic                             take_min;
  logic [lbct_pkg::IDX_W-1:0]       cand_idx;
  logic                             scan_last;
  logic                             out_free;
  logic                             load_out;
  logic                             hit_out;
  logic [lbct_pkg::WAY_W-1:0]       way_out;
  logic [lbct_pkg::TAG_W-1:0]       num_out;

  // Per-cycle scan compare
  assign tag_match = (way_tags[idx] == work.tag);
  assign take_min  = (idx == '0) || (way_ages[idx] < best_age);
  assign cand_idx  = take_min ? idx : best_idx;
  assign scan_last = (idx == lbct_pkg::LAST_WAY);
  assign age_next  = age_counter + lbct_pkg::AGE_W'(1);
  assign out_free  = !m_axis_tvalid || m_axis_tready;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      lbct_pkg::ST_IDLE: begin
        if (q_valid) begin
          state_next = q_item.bypass ? lbct_pkg::ST_DONE : lbct_pkg::ST_SCAN;
        end
      end
      lbct_pkg::ST_SCAN: begin
        if (tag_match || scan_last) begin
          state_next = lbct_pkg::ST_DONE;
        end
      end
      lbct_pkg::ST_DONE: begin
        if (out_free) begin
          state_next = lbct_pkg::ST_IDLE;
        end
      end
      default: state_next = lbct_pkg::ST_IDLE;
    endcase
  end

  // State-decoded controls
  always_comb begin
    q_pop    = 1'b0;
    load_out = 1'b0;
    case (state)
      lbct_pkg::ST_IDLE: q_pop    = q_valid;
      lbct_pkg::ST_DONE: load_out = out_free;
      default: begin
        q_pop    = 1'b0;
        load_out = 1'b0;
      end
    endcase
  end

  // Result fields
  always_comb begin
    if (work.bypass) begin
      hit_out = 1'b0;
      way_out = '0;
    end else begin
      hit_out = sel_hit;
      way_out = lbct_pkg::way_field(sel_idx);
    end
    num_out = work.tag;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lbct_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Work item, scan index and running minimum
  always_ff @(posedge clk) begin
    if (q_pop) begin
      work <= q_item;
      idx  <= '0;
    end
    if (state == lbct_pkg::ST_SCAN) begin
      idx <= idx + lbct_pkg::IDX_W'(1);
      if (take_min) begin
        best_age <= way_ages[idx];
        best_idx <= idx;
      end
      if (tag_match) begin
        sel_hit <= 1'b1;
        sel_idx <= idx;
      end else if (scan_last) begin
        sel_hit <= 1'b0;
        sel_idx <= cand_idx;
      end
    end
  end

  // Age counter, tags and age stamps
  always_ff @(posedge clk) begin
    if (rst) begin
      age_counter <= '0;
      for (int i = 0; i < lbct_pkg::WAYS; i++) begin
        way_tags[i] <= '0;
        way_ages[i] <= '0;
      end
    end else begin
      if (q_pop && !q_item.bypass) begin
        age_counter <= age_next;
        if (age_next == '0) begin
          for (int i = 0; i < lbct_pkg::WAYS; i++) begin
            way_ages[i] <= '0;
          end
        end
      end
      if (load_out && !work.bypass) begin
        way_tags[sel_idx] <= work.tag;
        way_ages[sel_idx] <= age_counter;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (load_out) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_axis_tdata <= lbct_pkg::OUT_DATA_W'({num_out, way_out, hit_out});
      m_axis_tuser <= work.bypass;
    end
  end

  // Checks
  `LBCT_ASSERT_NOW(a_scan_not_bypass, clk, rst, state == lbct_pkg::ST_SCAN, !work.bypass, "bypass transaction entered the way scan")
  `LBCT_ASSERT_NOW(a_scan_in_range, clk, rst, state == lbct_pkg::ST_SCAN, idx <= lbct_pkg::LAST_WAY, "scan index beyond last way")
  `LBCT_ASSERT_NEXT(a_done_loads, clk, rst, load_out, m_axis_tvalid, "result not presented after completion")
  `LBCT_ASSERT_NEXT(a_stamp_written, clk, rst, load_out && !work.bypass, (way_tags[$past(sel_idx)] == work.tag) && (way_ages[$past(sel_idx)] == age_counter), "selected way not tagged and stamped")

endmodule

/* rtl/core/lru_block_cache_tags.sv */
// ----------------------------------------------------------------------------
// lru_block_cache_tags
// Tag and LRU replacement logic of a fully associative block cache.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_axis carries one signed block word per transaction.
//   A non-negative word is an uncompressed block: the result has bypass set
//   (in m_axis_tuser), hit and way zero, and the cache state is untouched.
//   A negative word names compressed block -word (saturated to 31 bits); the
//   result reports hit and the way hit or filled, and the LRU stamps update.
//   Output stream m_axis returns exactly one result per input, in order.
// Timing:
//   A compressed lookup walks the ways one per cycle through a single tag and
//   age compare port: a load step, the scan (which stops on a hit) and an
//   update step. A bypass item skips the scan. A two-entry queue in front
//   lets new transactions be accepted while the scan runs.
// Reset and stalls:
//   rst clears all tags, age stamps, the age counter and the queue. While
//   m_axis_tready is low the finished result holds, the scan of the next item
//   waits in its update step, and s_axis_tready drops once the queue is full.
// ----------------------------------------------------------------------------
module lru_block_cache_tags (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [lbct_pkg::IN_DATA_W-1:0]  s_axis_tdata,   // [31:0] block_offset
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [lbct_pkg::OUT_DATA_W-1:0] m_axis_tdata,   // [0] hit, [4:1] way,
                                                          // [35:5] block_number, rest 0
  output logic                            m_axis_tuser    // [0] bypass
);

  logic            q_valid;
  logic            q_pop;
  lbct_pkg::item_t q_item;

  // Front: accept and classify
  lbct_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .q_valid       (q_valid),
    .q_pop         (q_pop),
    .q_item        (q_item)
  );

  // Back: way scan, replacement and result
  lbct_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_pop         (q_pop),
    .q_item        (q_item),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

/* sim/tb_lru_block_cache_tags.sv */
// ----------------------------------------------------------------------------
// tb_lru_block_cache_tags
// Self-checking bench for the block cache tag and LRU replacement logic.
// A short table of directed block words covers bypass words, the first fill
// after reset, a hit, most-negative saturation and a full set with eviction.
// A random phase follows, built mostly from compressed words drawn from a
// drifting working set, so that both hits and evictions happen. Every
// accepted word runs through a local model of the tags and age stamps. Each
// result transaction is checked against the oldest prediction. Both stream
// sides idle at random, except during one quiet stretch.
// ----------------------------------------------------------------------------
module tb_lru_block_cache_tags;

  localparam int RESET_CYCLES = 7;
  localparam int RANDOM_ITEMS = 800;
  localparam int QUIET_FIRST  = 300;
  localparam int QUIET_LAST   = 449;
  localparam int POOL_SIZE    = 24;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int NUM_ROWS     = 24;
  localparam int REPORT_MAX   = 10;

  // One lookup outcome, as carried by a result transaction
  typedef struct packed {
    logic                       bypass;
    logic                       hit;
    logic [lbct_pkg::WAY_W-1:0] way;
    logic [lbct_pkg::TAG_W-1:0] blk;
  } lookup_t;

  // Directed row: block word, whether the outcome is typed in, and that outcome
  typedef struct packed {
    logic [lbct_pkg::WORD_W-1:0] word;
    logic                        typed;
    lookup_t                     want;
  } row_t;

  logic                            clk;
  logic                            rst           = 1'b1;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [lbct_pkg::IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [lbct_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic                            m_axis_tuser;

  // Local copy of the cache tag state
  logic [lbct_pkg::TAG_W-1:0] way_tag   [lbct_pkg::WAYS];
  logic [lbct_pkg::AGE_W-1:0] way_stamp [lbct_pkg::WAYS];
  logic [lbct_pkg::AGE_W-1:0] access_clock;

  lookup_t     pending_lookups [$];
  row_t        directed_rows   [NUM_ROWS];
  logic [lbct_pkg::TAG_W-1:0] tag_pool [POOL_SIZE];
  logic        quiet = 1'b0;
  int          mismatches = 0;
  int          cycles = 0;

  lru_block_cache_tags dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Predict one lookup and update the local tags and stamps
  function automatic lookup_t lookup_block(input logic [lbct_pkg::WORD_W-1:0] word);
    lookup_t                     r;
    logic [lbct_pkg::WORD_W-1:0] mag;
    logic [lbct_pkg::AGE_W-1:0]  oldest;
    int                          victim;
    r = '0;
    // Uncompressed block: pass straight through, state untouched
    if (!word[lbct_pkg::WORD_W-1]) begin
      r.bypass = 1'b1;
      r.blk    = word[lbct_pkg::TAG_W-1:0];
      return r;
    end
    // Magnitude; the most negative word saturates to the largest tag
    mag = -word;
    if (mag[lbct_pkg::WORD_W-1]) mag = {1'b0, lbct_pkg::TAG_MAX};
    r.blk = mag[lbct_pkg::TAG_W-1:0];
    access_clock = access_clock + 1'b1;
    // Counter wrap clears every stamp (needs 2^32 accesses, not reached here)
    if (access_clock == '0) begin
      for (int i = 0; i < lbct_pkg::WAYS; i++) way_stamp[i] = '0;
    end
    // Search for the tag; on a miss fill the oldest way, lowest index on ties
    oldest = way_stamp[0];
    victim = 0;
    for (int i = 0; i < lbct_pkg::WAYS; i++) begin
      if (way_stamp[i] < oldest) begin
        oldest = way_stamp[i];
        victim = i;
      end
      if (way_tag[i] == r.blk) begin
        way_stamp[i] = access_clock;
        r.hit = 1'b1;
        r.way = lbct_pkg::WAY_W'(i);
        return r;
      end
    end
    way_tag[victim]   = r.blk;
    way_stamp[victim] = access_clock;
    r.way = lbct_pkg::WAY_W'(victim);
    return r;
  endfunction

  // Send one block word; predict once the transaction is accepted
  task automatic send_word(input logic [lbct_pkg::WORD_W-1:0] word, input logic typed,
                           input lookup_t want);
    lookup_t model;
    while (!quiet && $urandom_range(99) < 33) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= word;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    model = lookup_block(word);
    pending_lookups.push_back(typed ? want : model);
  endtask

  // Random block word: mostly compressed words from the working set
  function automatic logic [lbct_pkg::WORD_W-1:0] pick_word(input int live);
    logic [31:0] r;
    int          kind;
    r    = $urandom();
    kind = $urandom_range(99);
    if (kind < 15) return {1'b0, r[30:0]};
    if (kind < 25) return r;
    if (kind < 30) begin
      case (r[1:0])
        2'd0:    return 32'h8000_0000;
        2'd1:    return 32'h8000_0001;
        2'd2:    return 32'h7FFF_FFFF;
        default: return 32'hFFFF_FFFF;
      endcase
    end
    return -{1'b0, tag_pool[$urandom_range(live - 1)]};
  endfunction

  function automatic logic [lbct_pkg::TAG_W-1:0] fresh_tag();
    logic [31:0] r;
    r = $urandom();
    return (r[lbct_pkg::TAG_W-1:0] == '0) ? lbct_pkg::TAG_W'(1) : r[lbct_pkg::TAG_W-1:0];
  endfunction

  // Result side: random stalls, then compare against the oldest prediction
  always @(posedge clk) begin
    lookup_t got;
    lookup_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= quiet || ($urandom_range(99) >= 33);
      if (m_axis_tvalid && m_axis_tready) begin
        got.bypass = m_axis_tuser;
        got.hit    = m_axis_tdata[0];
        got.way    = m_axis_tdata[4:1];
        got.blk    = m_axis_tdata[35:5];
        if (pending_lookups.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("unexpected result: bypass=%0b hit=%0b way=%0d blk=%0h",
                     got.bypass, got.hit, got.way, got.blk);
        end else begin
          want = pending_lookups.pop_front();
          if (got.bypass !== want.bypass || got.hit !== want.hit ||
              got.way !== want.way || got.blk !== want.blk) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
              $display("mismatch: exp bypass=%0b hit=%0b way=%0d blk=%0h, %s%0b %s%0b %s%0d %s%0h",
                       want.bypass, want.hit, want.way, want.blk,
                       "got bypass=", got.bypass, "hit=", got.hit,
                       "way=", got.way, "blk=", got.blk);
          end
        end
      end
    end
  end

  // Stimulus and end of run
  initial begin
    int live;
    for (int i = 0; i < lbct_pkg::WAYS; i++) begin
      way_tag[i]   = '0;
      way_stamp[i] = '0;
    end
    access_clock = '0;
    for (int i = 0; i < POOL_SIZE; i++) tag_pool[i] = fresh_tag();

    // word, typed, {bypass, hit, way, blk}
    directed_rows = '{
      '{32'h0000_0000, 1'b1, '{1'b1, 1'b0, 4'd0, 31'h0000_0000}},
      '{32'h7FFF_FFFF, 1'b1, '{1'b1, 1'b0, 4'd0, 31'h7FFF_FFFF}},
      '{32'h5555_5555, 1'b1, '{1'b1, 1'b0, 4'd0, 31'h5555_5555}},
      // first fill after reset lands in way 0, then hits there
      '{32'hFFFF_FFFF, 1'b1, '{1'b0, 1'b0, 4'd0, 31'h0000_0001}},
      '{32'hFFFF_FFFF, 1'b1, '{1'b0, 1'b1, 4'd0, 31'h0000_0001}},
      // most negative word saturates; same tag as the largest magnitude
      '{32'h8000_0000, 1'b1, '{1'b0, 1'b0, 4'd1, 31'h7FFF_FFFF}},
      '{32'h8000_0001, 1'b1, '{1'b0, 1'b1, 4'd1, 31'h7FFF_FFFF}},
      // fill the remaining ways
      '{32'hFFFF_FFFE, 1'b0, '0}, '{32'hFFFF_FFFD, 1'b0, '0},
      '{32'hFFFF_FFFC, 1'b0, '0}, '{32'hFFFF_FFFB, 1'b0, '0},
      '{32'hFFFF_FFFA, 1'b0, '0}, '{32'hFFFF_FFF9, 1'b0, '0},
      '{32'hFFFF_FFF8, 1'b0, '0}, '{32'hFFFF_FFF7, 1'b0, '0},
      '{32'hFFFF_FFF6, 1'b0, '0}, '{32'hFFFF_FFF5, 1'b0, '0},
      '{32'hFFFF_FFF4, 1'b0, '0}, '{32'hFFFF_FFF3, 1'b0, '0},
      '{32'hFFFF_FFF2, 1'b0, '0}, '{32'hFFFF_FFF1, 1'b0, '0},
      // set is full: evict the oldest, re-miss the evicted tag, then hit
      '{32'hFFFF_FFF0, 1'b0, '0},
      '{32'hFFFF_FFFF, 1'b0, '0},
      '{32'hFFFF_FFFE, 1'b0, '0}
    };

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i])
      send_word(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].want);

    // Random phase: working set drifts every hundred transactions
    live = 8;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 100 == 0) begin
        live = $urandom_range(4, POOL_SIZE);
        for (int k = 0; k < 4; k++) tag_pool[$urandom_range(POOL_SIZE - 1)] = fresh_tag();
      end
      if (n == QUIET_FIRST) quiet <= 1'b1;
      if (n == QUIET_LAST + 1) quiet <= 1'b0;
      send_word(pick_word(live), 1'b0, '0);
    end
    s_axis_tvalid <= 1'b0;

    while (pending_lookups.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && pending_lookups.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
